FILE: rtl/salru_pkg.sv
// Shared types, constants and helpers for the set-associative LRU tag store.
`default_nettype none
package salru_pkg;

	localparam int SETS = 64;
	localparam int WAYS = 8;

	localparam int ADDR_W = 32;
	localparam int TAG_W = 29;
	localparam int CNT_W = 32;
	localparam int OFF_W = 5;
	localparam int SETB_W = 3;
	localparam int CFG_W = 5;
	localparam int CFG_IDX_W = 1;
	localparam int MODE_W = 3;
	localparam int WAY_OUT_W = 3;
	localparam int EVICT_W = 2;
	localparam int NUM_CNT = 6;
	localparam int SHAMT_W = 6;

	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int AGE_W = WAY_W;
	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;

	localparam logic [OFF_W-1:0] OFFSET_BITS_RST = OFF_W'(9);
	localparam logic [SETB_W-1:0] SET_BITS_RST = SETB_W'(6);

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS = 1'd1;

	localparam logic [MODE_W-1:0] MODE_READ_LOOKUP = 3'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE_LOOKUP = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FILL = 3'd2;
	localparam logic [MODE_W-1:0] MODE_READ_TOUCH = 3'd3;
	localparam logic [MODE_W-1:0] MODE_WRITE_TOUCH = 3'd4;

	localparam logic [EVICT_W-1:0] EVICT_NONE = 2'd0;
	localparam logic [EVICT_W-1:0] EVICT_CLEAN = 2'd1;
	localparam logic [EVICT_W-1:0] EVICT_DIRTY = 2'd2;

	localparam int CNT_RD_ACC = 0;
	localparam int CNT_WR_ACC = 1;
	localparam int CNT_RD_MISS = 2;
	localparam int CNT_WR_MISS = 3;
	localparam int CNT_CLEAN_EV = 4;
	localparam int CNT_DIRTY_EV = 5;

	localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WAYS - 1);

	typedef struct packed {
		logic [WAYS-1:0][TAG_W-1:0] tags;
		logic [WAYS-1:0] valid;
		logic [WAYS-1:0] dirty;
		logic [WAYS-1:0][AGE_W-1:0] age;
	} row_t;

	typedef struct packed {
		logic read;
		logic commit;
	} cmd_t;

	function automatic row_t reset_row();
		row_t r;
		r.tags = '0;
		r.valid = '0;
		r.dirty = '0;
		for (int j = 0; j < WAYS; j++) begin
			r.age[j] = AGE_W'(WAYS - 1 - j);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/salru_ctrl.sv
// Controller state machine: request intake, lookup sequencing and result handoff.
`default_nettype none
module salru_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output salru_pkg::cmd_t      cmd
);
	import salru_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LOOK = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic out_valid_q;

	always_comb begin
		in_ready = (state_q == S_IDLE);
		cmd.read = in_valid && (state_q == S_IDLE);
		cmd.commit = (state_q == S_LOOK) && (!out_valid_q || out_ready);
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				if (cmd.commit) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: rtl/salru_dpath.sv
// Datapath: configuration, set row memory, tag match, LRU update and counters.
`default_nettype none
module salru_dpath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [salru_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [salru_pkg::CFG_W-1:0]       cfg_data,
	input  wire salru_pkg::cmd_t                   cmd,
	input  wire logic [salru_pkg::MODE_W-1:0]      mode,
	input  wire logic [salru_pkg::ADDR_W-1:0]      address,
	output logic                                   hit,
	output logic [salru_pkg::WAY_OUT_W-1:0]        way,
	output logic [salru_pkg::EVICT_W-1:0]          eviction,
	output logic [salru_pkg::CNT_W-1:0]            rd_access_cnt,
	output logic [salru_pkg::CNT_W-1:0]            wr_access_cnt,
	output logic [salru_pkg::CNT_W-1:0]            rd_miss_cnt,
	output logic [salru_pkg::CNT_W-1:0]            wr_miss_cnt,
	output logic [salru_pkg::CNT_W-1:0]            clean_evict_cnt,
	output logic [salru_pkg::CNT_W-1:0]            dirty_evict_cnt
);
	import salru_pkg::*;

	logic [OFF_W-1:0] offset_bits_q;
	logic [SETB_W-1:0] set_bits_q;

	logic [ADDR_W-1:0] shifted;
	logic [ADDR_W-1:0] set_mask;
	logic [SHAMT_W-1:0] tag_shamt;
	logic [SET_W-1:0] set_in;
	logic [TAG_W-1:0] tag_in;

	logic [SET_W-1:0] set_s1;
	logic [TAG_W-1:0] tag_s1;
	logic [MODE_W-1:0] mode_s1;
	row_t rd_row_s1;

	row_t mem [SETS];
	logic [SETS-1:0] row_init_q;

	row_t cur_row;
	row_t new_row;
	logic [WAYS-1:0] match;
	logic hit_c;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] victim;
	logic [WAY_W-1:0] tgt;
	logic do_young;
	logic [AGE_W-1:0] tgt_age;
	logic [WAY_W-1:0] way_c;
	logic [EVICT_W-1:0] evict_c;

	logic [CNT_W-1:0] cnt_q [NUM_CNT];
	logic hit_q;
	logic [WAY_OUT_W-1:0] way_q;
	logic [EVICT_W-1:0] evict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= OFFSET_BITS_RST;
			set_bits_q <= SET_BITS_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_OFFSET_BITS: offset_bits_q <= cfg_data[OFF_W-1:0];
				REG_SET_BITS: set_bits_q <= cfg_data[SETB_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		shifted = address >> offset_bits_q;
		set_mask = (ADDR_W'(1) << set_bits_q) - ADDR_W'(1);
		set_in = SET_W'((shifted & set_mask) % SETS);
		tag_shamt = SHAMT_W'(offset_bits_q) + SHAMT_W'(set_bits_q);
		if (tag_shamt >= SHAMT_W'(ADDR_W)) begin
			tag_in = '0;
		end else begin
			tag_in = TAG_W'(address >> tag_shamt);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			set_s1 <= set_in;
			tag_s1 <= tag_in;
			mode_s1 <= mode;
			rd_row_s1 <= mem[set_in];
		end
		if (cmd.commit) begin
			mem[set_s1] <= new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_init_q <= '0;
		end else if (cmd.commit) begin
			row_init_q[set_s1] <= 1'b1;
		end
	end

	always_comb begin
		cur_row = row_init_q[set_s1] ? rd_row_s1 : reset_row();

		hit_c = 1'b0;
		hit_way = '0;
		for (int i = 0; i < WAYS; i++) begin
			match[i] = cur_row.valid[i] && (cur_row.tags[i] == tag_s1);
		end
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_c = 1'b1;
				hit_way = WAY_W'(i);
			end
		end

		victim = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (cur_row.age[i] == AGE_OLDEST) begin
				victim = WAY_W'(i);
			end
		end

		new_row = cur_row;
		tgt = hit_way;
		do_young = 1'b0;
		evict_c = EVICT_NONE;
		way_c = hit_way;

		case (mode_s1) inside
			MODE_FILL: begin
				tgt = victim;
				way_c = victim;
				do_young = 1'b1;
				if (cur_row.valid[victim]) begin
					evict_c = cur_row.dirty[victim] ? EVICT_DIRTY : EVICT_CLEAN;
				end
				new_row.tags[victim] = tag_s1;
				new_row.valid[victim] = 1'b1;
				new_row.dirty[victim] = 1'b0;
			end
			MODE_READ_TOUCH, MODE_WRITE_TOUCH: begin
				do_young = hit_c;
				if (hit_c && (mode_s1 == MODE_WRITE_TOUCH)) begin
					new_row.dirty[hit_way] = 1'b1;
				end
			end
			default: ;
		endcase

		tgt_age = cur_row.age[tgt];
		if (do_young) begin
			for (int i = 0; i < WAYS; i++) begin
				if (WAY_W'(i) == tgt) begin
					new_row.age[i] = '0;
				end else if (cur_row.age[i] < tgt_age) begin
					new_row.age[i] = cur_row.age[i] + AGE_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CNT; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (cmd.commit) begin
			case (mode_s1)
				MODE_READ_LOOKUP: begin
					cnt_q[CNT_RD_ACC] <= cnt_q[CNT_RD_ACC] + CNT_W'(1);
					if (!hit_c) begin
						cnt_q[CNT_RD_MISS] <= cnt_q[CNT_RD_MISS] + CNT_W'(1);
					end
				end
				MODE_WRITE_LOOKUP: begin
					cnt_q[CNT_WR_ACC] <= cnt_q[CNT_WR_ACC] + CNT_W'(1);
					if (!hit_c) begin
						cnt_q[CNT_WR_MISS] <= cnt_q[CNT_WR_MISS] + CNT_W'(1);
					end
				end
				MODE_FILL: begin
					if (evict_c == EVICT_CLEAN) begin
						cnt_q[CNT_CLEAN_EV] <= cnt_q[CNT_CLEAN_EV] + CNT_W'(1);
					end
					if (evict_c == EVICT_DIRTY) begin
						cnt_q[CNT_DIRTY_EV] <= cnt_q[CNT_DIRTY_EV] + CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q <= hit_c;
			way_q <= WAY_OUT_W'(way_c);
			evict_q <= evict_c;
		end
	end

	assign hit = hit_q;
	assign way = way_q;
	assign eviction = evict_q;
	assign rd_access_cnt = cnt_q[CNT_RD_ACC];
	assign wr_access_cnt = cnt_q[CNT_WR_ACC];
	assign rd_miss_cnt = cnt_q[CNT_RD_MISS];
	assign wr_miss_cnt = cnt_q[CNT_WR_MISS];
	assign clean_evict_cnt = cnt_q[CNT_CLEAN_EV];
	assign dirty_evict_cnt = cnt_q[CNT_DIRTY_EV];

endmodule
`default_nettype wire

FILE: rtl/set_assoc_cache_lru_tags_top.sv
// Top level of the set-associative cache tag store with true-LRU replacement.
`default_nettype none
// For each request, the set row (tags, valid, dirty and ages of all ways) is
// first read from a single-port-read, single-port-write row memory; the match,
// victim choice, age update and row write-back happen in the second step. A
// new request is not accepted until the previous one has written back; a result
// not taken holds the second step until it is. Counter outputs always show the
// totals after the most recent result. There is no clearing pass after reset: a
// per-set flag marks rows never written, and those read as empty with reset ages.
// Configuration must be written only while idle; the block does not enforce it.
module set_assoc_cache_lru_tags_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [salru_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [salru_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [salru_pkg::MODE_W-1:0]      mode,
	input  wire logic [salru_pkg::ADDR_W-1:0]      address,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   hit,
	output logic [salru_pkg::WAY_OUT_W-1:0]        way,
	output logic [salru_pkg::EVICT_W-1:0]          eviction,
	output logic [salru_pkg::CNT_W-1:0]            rd_access_cnt,
	output logic [salru_pkg::CNT_W-1:0]            wr_access_cnt,
	output logic [salru_pkg::CNT_W-1:0]            rd_miss_cnt,
	output logic [salru_pkg::CNT_W-1:0]            wr_miss_cnt,
	output logic [salru_pkg::CNT_W-1:0]            clean_evict_cnt,
	output logic [salru_pkg::CNT_W-1:0]            dirty_evict_cnt
);
	import salru_pkg::*;

	cmd_t cmd;

	salru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	salru_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.mode            (mode),
		.address         (address),
		.hit             (hit),
		.way             (way),
		.eviction        (eviction),
		.rd_access_cnt   (rd_access_cnt),
		.wr_access_cnt   (wr_access_cnt),
		.rd_miss_cnt     (rd_miss_cnt),
		.wr_miss_cnt     (wr_miss_cnt),
		.clean_evict_cnt (clean_evict_cnt),
		.dirty_evict_cnt (dirty_evict_cnt)
	);

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the set-associative cache tag store with true-LRU replacement.
module testbench;
	import salru_pkg::*;

	localparam int NUM_LAYOUTS = 9;
	localparam int LAYOUT_REQS = 190;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [MODE_W-1:0] op;
		logic [ADDR_W-1:0] addr;
	} request_t;

	typedef struct packed {
		logic hit;
		logic [WAY_OUT_W-1:0] way;
		logic [EVICT_W-1:0] eviction;
		logic [CNT_W-1:0] rd_acc;
		logic [CNT_W-1:0] wr_acc;
		logic [CNT_W-1:0] rd_miss;
		logic [CNT_W-1:0] wr_miss;
		logic [CNT_W-1:0] clean_ev;
		logic [CNT_W-1:0] dirty_ev;
	} access_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_OFFSET_BITS;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [MODE_W-1:0] mode = MODE_READ_LOOKUP;
	logic [ADDR_W-1:0] address = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;
	logic [WAY_OUT_W-1:0] way;
	logic [EVICT_W-1:0] eviction;
	logic [CNT_W-1:0] rd_access_cnt;
	logic [CNT_W-1:0] wr_access_cnt;
	logic [CNT_W-1:0] rd_miss_cnt;
	logic [CNT_W-1:0] wr_miss_cnt;
	logic [CNT_W-1:0] clean_evict_cnt;
	logic [CNT_W-1:0] dirty_evict_cnt;

	logic [TAG_W-1:0] tag_mem [SETS][WAYS];
	logic valid_mem [SETS][WAYS];
	logic dirty_mem [SETS][WAYS];
	logic [AGE_W-1:0] age_mem [SETS][WAYS];
	logic [CNT_W-1:0] stat_cnt [NUM_CNT];
	int layout_offset;
	int layout_sets;

	request_t pending_requests[$];
	access_result_t predicted_results[$];
	int queued_reqs = 0;
	int accepted_reqs = 0;
	int results_checked = 0;
	int hits_seen = 0;
	int fail_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic req_taken = 1'b0;
	logic pressure_go = 1'b0;
	logic hold_off = 1'b0;

	set_assoc_cache_lru_tags_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.address(address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit),
		.way(way),
		.eviction(eviction),
		.rd_access_cnt(rd_access_cnt),
		.wr_access_cnt(wr_access_cnt),
		.rd_miss_cnt(rd_miss_cnt),
		.wr_miss_cnt(wr_miss_cnt),
		.clean_evict_cnt(clean_evict_cnt),
		.dirty_evict_cnt(dirty_evict_cnt)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void make_youngest(int s, int w);
		logic [AGE_W-1:0] old_age;
		old_age = age_mem[s][w];
		for (int i = 0; i < WAYS; i++) begin
			if (age_mem[s][i] < old_age) begin
				age_mem[s][i]++;
			end
		end
		age_mem[s][w] = '0;
	endfunction

	function automatic access_result_t cache_access(logic [MODE_W-1:0] op, logic [ADDR_W-1:0] addr);
		access_result_t r;
		logic [63:0] a;
		logic [TAG_W-1:0] tg;
		int s;
		int victim;
		r = '0;
		a = {32'd0, addr};
		s = int'(((a >> layout_offset) & ((64'd1 << layout_sets) - 64'd1)) % SETS);
		tg = TAG_W'(a >> (layout_offset + layout_sets));
		for (int i = 0; i < WAYS; i++) begin
			if (valid_mem[s][i] && tag_mem[s][i] == tg) begin
				r.hit = 1'b1;
				r.way = WAY_OUT_W'(i);
				break;
			end
		end
		case (op)
			MODE_READ_LOOKUP: begin
				stat_cnt[CNT_RD_ACC]++;
				if (!r.hit) stat_cnt[CNT_RD_MISS]++;
			end
			MODE_WRITE_LOOKUP: begin
				stat_cnt[CNT_WR_ACC]++;
				if (!r.hit) stat_cnt[CNT_WR_MISS]++;
			end
			MODE_FILL: begin
				victim = 0;
				for (int i = 0; i < WAYS; i++) begin
					if (age_mem[s][i] == AGE_OLDEST) begin
						victim = i;
						break;
					end
				end
				if (valid_mem[s][victim]) begin
					if (dirty_mem[s][victim]) begin
						r.eviction = EVICT_DIRTY;
						stat_cnt[CNT_DIRTY_EV]++;
					end else begin
						r.eviction = EVICT_CLEAN;
						stat_cnt[CNT_CLEAN_EV]++;
					end
				end
				tag_mem[s][victim] = tg;
				valid_mem[s][victim] = 1'b1;
				dirty_mem[s][victim] = 1'b0;
				make_youngest(s, victim);
				r.way = WAY_OUT_W'(victim);
			end
			MODE_READ_TOUCH, MODE_WRITE_TOUCH: begin
				if (r.hit) begin
					if (op == MODE_WRITE_TOUCH) dirty_mem[s][r.way] = 1'b1;
					make_youngest(s, int'(r.way));
				end
			end
			default: begin
			end
		endcase
		r.rd_acc = stat_cnt[CNT_RD_ACC];
		r.wr_acc = stat_cnt[CNT_WR_ACC];
		r.rd_miss = stat_cnt[CNT_RD_MISS];
		r.wr_miss = stat_cnt[CNT_WR_MISS];
		r.clean_ev = stat_cnt[CNT_CLEAN_EV];
		r.dirty_ev = stat_cnt[CNT_DIRTY_EV];
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] make_address(logic [ADDR_W-1:0] tg, int s);
		logic [63:0] a;
		a = (64'(tg) << (layout_offset + layout_sets)) | (64'(s) << layout_offset)
			| (64'($urandom()) & ((64'd1 << layout_offset) - 64'd1));
		return ADDR_W'(a);
	endfunction

	task automatic queue_request(logic [MODE_W-1:0] op, logic [ADDR_W-1:0] addr);
		request_t req;
		req.op = op;
		req.addr = addr;
		pending_requests.push_back(req);
		queued_reqs++;
	endtask

	always @(negedge clk) begin : driver
		request_t req;
		if (arst_n && !(in_valid && !req_taken)) begin
			if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req = pending_requests.pop_front();
				in_valid <= 1'b1;
				mode <= req.op;
				address <= req.addr;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= arst_n && !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin : hold_receiver
		wait (pressure_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin : monitor
		access_result_t got;
		access_result_t want;
		req_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = {hit, way, eviction, rd_access_cnt, wr_access_cnt, rd_miss_cnt,
					wr_miss_cnt, clean_evict_cnt, dirty_evict_cnt};
				if (predicted_results.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("unexpected result with no request outstanding");
				end else begin
					want = predicted_results.pop_front();
					results_checked++;
					if (want.hit) hits_seen++;
					if (got !== want) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							$display("mismatch on result %0d", results_checked);
							$display("  expected hit=%b way=%0d ev=%0d cnt=%0d %0d %0d %0d %0d %0d",
								want.hit, want.way, want.eviction, want.rd_acc, want.wr_acc,
								want.rd_miss, want.wr_miss, want.clean_ev, want.dirty_ev);
							$display("  actual   hit=%b way=%0d ev=%0d cnt=%0d %0d %0d %0d %0d %0d",
								got.hit, got.way, got.eviction, got.rd_acc, got.wr_acc,
								got.rd_miss, got.wr_miss, got.clean_ev, got.dirty_ev);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				predicted_results.push_back(cache_access(mode, address));
				accepted_reqs++;
			end
		end
	end

	initial begin : stimulus
		int off_plan [NUM_LAYOUTS];
		int set_plan [NUM_LAYOUTS];
		logic [ADDR_W-1:0] pool_tag [12];
		int pool_set [3];
		logic [ADDR_W-1:0] a;
		int n;
		off_plan = '{9, 3, 20, 31, 5, 12, 1, 18, 2};
		set_plan = '{6, 0, 6, 23, 2, 5, 1, 3, 0};
		for (int s = 0; s < SETS; s++) begin
			for (int w = 0; w < WAYS; w++) begin
				tag_mem[s][w] = '0;
				valid_mem[s][w] = 1'b0;
				dirty_mem[s][w] = 1'b0;
				age_mem[s][w] = AGE_W'(WAYS - 1 - w);
			end
		end
		for (int i = 0; i < NUM_CNT; i++) stat_cnt[i] = '0;
		layout_offset = int'(OFFSET_BITS_RST);
		layout_sets = int'(SET_BITS_RST);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < NUM_LAYOUTS; p++) begin
			if (p != 0) begin
				@(negedge clk);
				cfg_write <= 1'b1;
				cfg_index <= REG_OFFSET_BITS;
				cfg_data <= CFG_W'(off_plan[p]);
				@(negedge clk);
				cfg_index <= REG_SET_BITS;
				cfg_data <= CFG_W'(set_plan[p]);
				@(negedge clk);
				cfg_write <= 1'b0;
				layout_offset = off_plan[p] & 31;
				layout_sets = set_plan[p] & 7;
			end
			@(posedge clk);
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 46; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 46; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase

			if (p == 0) begin
				queue_request(MODE_READ_LOOKUP, '0);
				queue_request(MODE_FILL, '0);
				queue_request(MODE_READ_LOOKUP, '0);
				queue_request(MODE_FILL, '0);
				queue_request(MODE_WRITE_TOUCH, '0);
				queue_request(MODE_READ_TOUCH, '0);
				queue_request(MODE_READ_TOUCH, '1);
				queue_request(MODE_WRITE_LOOKUP, '1);
				for (int m = int'(MODE_WRITE_TOUCH) + 1; m < (1 << MODE_W); m++)
					queue_request(MODE_W'(m), '0);
				for (int t = 1; t <= 9; t++) queue_request(MODE_FILL, make_address(t, 0));
				queue_request(MODE_WRITE_LOOKUP, make_address(9, 0));
				queue_request(MODE_READ_LOOKUP, 32'h8000_0000);
			end

			for (int k = 0; k < 12; k++) pool_tag[k] = $urandom();
			for (int k = 0; k < 3; k++) pool_set[k] = $urandom_range((1 << layout_sets) - 1);
			n = 0;
			while (n < LAYOUT_REQS) begin
				if ($urandom_range(99) < 20) begin
					queue_request(MODE_W'($urandom_range((1 << MODE_W) - 1)), $urandom());
					n++;
				end else begin
					a = make_address(pool_tag[$urandom_range(11)], pool_set[$urandom_range(2)]);
					queue_request($urandom_range(1) ? MODE_WRITE_LOOKUP : MODE_READ_LOOKUP, a);
					n++;
					if ($urandom_range(1)) begin
						queue_request(MODE_FILL, a);
						n++;
					end
					queue_request($urandom_range(1) ? MODE_WRITE_TOUCH : MODE_READ_TOUCH, a);
					n++;
				end
			end
			if (p == 0) pressure_go = 1'b1;

			while (accepted_reqs != queued_reqs || predicted_results.size() != 0)
				@(negedge clk);
			repeat (4) @(negedge clk);
		end

		repeat (8) @(negedge clk);
		if (predicted_results.size() != 0) begin
			fail_count += predicted_results.size();
			$display("%0d results never arrived", predicted_results.size());
		end
		$display("Covered %0d requests across %0d address layouts, including a long output stall.",
			results_checked, NUM_LAYOUTS);
		$display("Saw %0d hits, %0d clean and %0d dirty evictions; %0d failures.",
			hits_seen, stat_cnt[CNT_CLEAN_EV], stat_cnt[CNT_DIRTY_EV], fail_count);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#3000000;
		$display("timeout after %0d of %0d requests checked", results_checked, queued_reqs);
		$display("FAIL");
		$finish;
	end
endmodule
